// File: src/bblur_pkg.sv
// Shared types and constants for the 3x3 RGB box blur unit.
`default_nettype none

package bblur_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CFG_W_W = 12;
    localparam int ROW_W = 16;
    localparam int CMP_W = ((COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W) + 1;
    localparam int PIX_W = 24;
    localparam int CSUM_W = 10;
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int MAX_RESULTS = 2;

    localparam logic [CMP_W-1:0] CMP_ONE = CMP_W'(1);
    localparam logic [CMP_W-1:0] CMP_MAX_W = CMP_W'(MAX_WIDTH);
    localparam logic [CFG_W_W-1:0] WIDTH_RESET = CFG_W_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

    localparam logic CFG_IDX_WIDTH = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_FL_RD,
        ST_FL_ACC,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic run_last;
        logic frame_last;
    } res_t;

    typedef struct packed {
        logic [PIX_W-1:0] data;
        logic run_last;
        logic frame_last;
    } out_t;

endpackage

`default_nettype wire

// File: src/box_blur_3x3_rgb_unit.sv
// Streaming 3x3 box blur of an RGB frame with two line stores.
//
// Pixels enter on the slave stream in raster order (tuser = 0), blurred pixels leave on the
// master stream. Each result is the per-channel mean of the in-frame neighbors, rounded half
// up. Result (y, x) is produced when pixel (y+1, x+1) arrives; the last pixel of a row also
// closes the last column, so one transaction can give two results. After the whole frame,
// flush transactions (tuser = 1) emit the final row, one pixel each, the last with tuser set.
// A pixel transaction reads the line stores, updates the window and writes back, then does
// one reciprocal-multiply divide per result. A flush reads and accumulates each neighbor
// column from the line stores in turn, then does one divide. Results go into a four-entry
// output queue, so a new transaction is accepted while earlier results wait; when the
// receiver stalls the queue fills and tready drops. Reset is asynchronous and takes effect
// at once: positions clear, width is 640 and height 480. The line stores are not cleared
// and hold nothing valid until written. A register write restarts the frame.
`default_nettype none

module box_blur_3x3_rgb_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: in_blue, in_green, in_red.
    input  wire logic [23:0] s_tdata,
    // s_tuser fields from bit 0: action.
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: out_blue, out_green, out_red.
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    // m_tuser fields from bit 0: frame_last.
    output logic             m_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    bblur_pkg::state_t state_reg, state_next;

    logic [bblur_pkg::COL_W-1:0] col_reg, col_next;
    logic [bblur_pkg::ROW_W-1:0] row_reg, row_next;
    logic [bblur_pkg::COL_W-1:0] flush_reg, flush_next;
    logic [bblur_pkg::CFG_W_W-1:0] width_reg, width_next;
    logic [bblur_pkg::ROW_W-1:0] height_reg, height_next;
    logic [2:0][bblur_pkg::CSUM_W-1:0] win0_reg, win0_next;
    logic [2:0][bblur_pkg::CSUM_W-1:0] win1_reg, win1_next;
    logic [1:0] res_num_reg, res_num_next;
    logic res_idx_reg, res_idx_next;

    logic [bblur_pkg::PIX_W-1:0] pix_reg, pix_next;
    bblur_pkg::res_t res_reg [2];
    bblur_pkg::res_t res_next [2];
    logic [2:0][bblur_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic [bblur_pkg::CNT_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [bblur_pkg::COL_W-1:0] fx_reg, fx_next;
    logic [bblur_pkg::COL_W-1:0] fhi_reg, fhi_next;

    bblur_pkg::out_t fifo_mem [bblur_pkg::FIFO_DEPTH];
    logic [bblur_pkg::FIFO_AW-1:0] head_reg, head_next;
    logic [bblur_pkg::FIFO_AW-1:0] tail_reg, tail_next;
    logic [bblur_pkg::FIFO_AW:0] fifo_cnt_reg, fifo_cnt_next;
    logic fifo_push;
    logic fifo_pop;
    bblur_pkg::out_t push_entry;

    // Line stores: one pixel per column, read address registered into the data.
    logic [bblur_pkg::PIX_W-1:0] upper_mem [bblur_pkg::MAX_WIDTH];
    logic [bblur_pkg::PIX_W-1:0] middle_mem [bblur_pkg::MAX_WIDTH];
    logic [bblur_pkg::PIX_W-1:0] up_rd_reg;
    logic [bblur_pkg::PIX_W-1:0] mid_rd_reg;
    logic [bblur_pkg::COL_W-1:0] rd_addr;
    logic mem_we;

    logic s_fire;
    logic [bblur_pkg::CMP_W-1:0] w_ext;
    logic [bblur_pkg::CMP_W-1:0] eff_w;
    logic [bblur_pkg::CMP_W-1:0] eff_w_m1;
    logic [bblur_pkg::ROW_W-1:0] eff_h;
    logic h_ge2;
    logic [bblur_pkg::CMP_W-1:0] col_inc;
    logic [bblur_pkg::CMP_W-1:0] fl_inc;
    logic col_end;
    logic flush_end;
    logic col_ge1;
    logic col_ge2;
    logic row_ge1;
    logic first_row;
    logic has1;
    logic has2;
    logic [bblur_pkg::COL_W-1:0] f_lo;
    logic [bblur_pkg::COL_W-1:0] f_hi;
    logic [2:0][bblur_pkg::CSUM_W-1:0] cur_sum;
    logic [2:0][bblur_pkg::SUM_W-1:0] sum1;
    logic [2:0][bblur_pkg::SUM_W-1:0] sum2;
    logic [2:0][bblur_pkg::SUM_W-1:0] fl_sum;
    logic [bblur_pkg::CNT_W-1:0] rows_n;
    logic [bblur_pkg::CNT_W-1:0] cols1_n;
    logic [bblur_pkg::CNT_W-1:0] cols2_n;
    logic [bblur_pkg::CNT_W-1:0] fl_cnt;
    bblur_pkg::res_t r1;
    bblur_pkg::res_t r2;
    bblur_pkg::res_t r_fl;
    bblur_pkg::res_t div_src;

    // Exact rounded mean for the divisors that occur (1, 2, 3, 4, 6, 9): the reciprocal
    // is rounded up to 20 fraction bits, which is exact for sums below 4096.
    function automatic logic [7:0] div_round(input logic [bblur_pkg::SUM_W-1:0] s,
                                             input logic [bblur_pkg::CNT_W-1:0] n);
        logic [bblur_pkg::SUM_W-1:0] x;
        logic [20:0] m;
        logic [bblur_pkg::SUM_W+20:0] p;
        x = s + {{(bblur_pkg::SUM_W-bblur_pkg::CNT_W+1){1'b0}}, n[bblur_pkg::CNT_W-1:1]};
        case (n)
            4'd2:    m = 21'd524288;
            4'd3:    m = 21'd349526;
            4'd4:    m = 21'd262144;
            4'd6:    m = 21'd174763;
            4'd9:    m = 21'd116509;
            default: m = 21'd1048576;
        endcase
        p = x * m;
        return p[27:20];
    endfunction

    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == bblur_pkg::ST_IDLE) &&
                      (fifo_cnt_reg <= (bblur_pkg::FIFO_AW+1)'(bblur_pkg::FIFO_DEPTH -
                                                              bblur_pkg::MAX_RESULTS));

    // Effective frame size: zero counts as one, width saturates at the line store depth.
    assign w_ext = {{(bblur_pkg::CMP_W-bblur_pkg::CFG_W_W){1'b0}}, width_reg};
    assign eff_w = (width_reg == '0) ? bblur_pkg::CMP_ONE :
                   (w_ext > bblur_pkg::CMP_MAX_W) ? bblur_pkg::CMP_MAX_W : w_ext;
    assign eff_w_m1 = eff_w - bblur_pkg::CMP_ONE;
    assign eff_h = (height_reg == '0) ? bblur_pkg::ROW_W'(1) : height_reg;
    assign h_ge2 = (eff_h[bblur_pkg::ROW_W-1:1] != '0);

    assign col_inc = {{(bblur_pkg::CMP_W-bblur_pkg::COL_W){1'b0}}, col_reg} +
                     bblur_pkg::CMP_ONE;
    assign fl_inc = {{(bblur_pkg::CMP_W-bblur_pkg::COL_W){1'b0}}, flush_reg} +
                    bblur_pkg::CMP_ONE;
    assign col_end = (col_inc >= eff_w);
    assign flush_end = (fl_inc >= eff_w);
    assign col_ge1 = (col_reg != '0);
    assign col_ge2 = (col_reg[bblur_pkg::COL_W-1:1] != '0);
    assign row_ge1 = (row_reg != '0);
    assign first_row = (row_reg[bblur_pkg::ROW_W-1:1] == '0);
    assign has1 = row_ge1 && col_ge1;
    assign has2 = row_ge1 && col_end;

    assign f_lo = (flush_reg == '0) ? '0 : flush_reg - 1'b1;
    assign f_hi = (fl_inc < eff_w) ? fl_inc[bblur_pkg::COL_W-1:0]
                                   : eff_w_m1[bblur_pkg::COL_W-1:0];

    assign rows_n = first_row ? 4'd2 : 4'd3;
    assign cols1_n = col_ge2 ? 4'd3 : 4'd2;
    assign cols2_n = col_ge1 ? 4'd2 : 4'd1;
    assign fl_cnt = acc_cnt_reg + (h_ge2 ? 4'd2 : 4'd1);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            cur_sum[ch] = {2'b00, mid_rd_reg[8*ch +: 8]} + {2'b00, pix_reg[8*ch +: 8]} +
                          (first_row ? 10'd0 : {2'b00, up_rd_reg[8*ch +: 8]});
            sum1[ch] = {2'b00, col_ge2 ? win1_reg[ch] : 10'd0} + {2'b00, win0_reg[ch]} +
                       {2'b00, cur_sum[ch]};
            sum2[ch] = {2'b00, col_ge1 ? win0_reg[ch] : 10'd0} + {2'b00, cur_sum[ch]};
            fl_sum[ch] = acc_reg[ch] + {4'd0, mid_rd_reg[8*ch +: 8]} +
                         (h_ge2 ? {4'd0, up_rd_reg[8*ch +: 8]} : 12'd0);
        end
    end

    always_comb
    begin
        r1.sum = sum1;
        r1.cnt = rows_n * cols1_n;
        r1.run_last = !has2;
        r1.frame_last = 1'b0;
        r2.sum = sum2;
        r2.cnt = rows_n * cols2_n;
        r2.run_last = 1'b1;
        r2.frame_last = 1'b0;
        r_fl.sum = fl_sum;
        r_fl.cnt = fl_cnt;
        r_fl.run_last = 1'b1;
        r_fl.frame_last = flush_end;
    end

    assign div_src = res_reg[res_idx_reg];
    assign push_entry.data = {div_round(div_src.sum[2], div_src.cnt),
                              div_round(div_src.sum[1], div_src.cnt),
                              div_round(div_src.sum[0], div_src.cnt)};
    assign push_entry.run_last = div_src.run_last;
    assign push_entry.frame_last = div_src.frame_last;

    assign fifo_push = (state_reg == bblur_pkg::ST_DIV);
    assign fifo_pop = m_tvalid && m_tready;
    assign mem_we = (state_reg == bblur_pkg::ST_PIX);
    assign rd_addr = (state_reg == bblur_pkg::ST_FL_RD) ? fx_reg : col_reg;

    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        row_next = row_reg;
        flush_next = flush_reg;
        width_next = width_reg;
        height_next = height_reg;
        win0_next = win0_reg;
        win1_next = win1_reg;
        res_num_next = res_num_reg;
        res_idx_next = res_idx_reg;
        pix_next = pix_reg;
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        acc_next = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        fx_next = fx_reg;
        fhi_next = fhi_reg;

        case (state_reg)
            bblur_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    pix_next = s_tdata;
                    if (s_tuser == bblur_pkg::ACT_PIXEL)
                    begin
                        if (row_reg < eff_h)
                        begin
                            state_next = bblur_pkg::ST_PIX;
                        end
                    end
                    else if (row_reg >= eff_h)
                    begin
                        fx_next = f_lo;
                        fhi_next = f_hi;
                        acc_next = '0;
                        acc_cnt_next = '0;
                        state_next = bblur_pkg::ST_FL_RD;
                    end
                end
            end

            bblur_pkg::ST_PIX:
            begin
                res_next[0] = has1 ? r1 : r2;
                res_next[1] = r2;
                res_num_next = {1'b0, has1} + {1'b0, has2};
                res_idx_next = 1'b0;
                if (col_end)
                begin
                    // The window restarts empty at the head of each row.
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    win0_next = '0;
                    win1_next = '0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    win1_next = win0_reg;
                    win0_next = cur_sum;
                end
                state_next = (has1 || has2) ? bblur_pkg::ST_DIV : bblur_pkg::ST_IDLE;
            end

            bblur_pkg::ST_FL_RD:
            begin
                state_next = bblur_pkg::ST_FL_ACC;
            end

            bblur_pkg::ST_FL_ACC:
            begin
                acc_next = fl_sum;
                acc_cnt_next = fl_cnt;
                if (fx_reg == fhi_reg)
                begin
                    res_next[0] = r_fl;
                    res_num_next = 2'd1;
                    res_idx_next = 1'b0;
                    if (flush_end)
                    begin
                        col_next = '0;
                        row_next = '0;
                        flush_next = '0;
                        win0_next = '0;
                        win1_next = '0;
                    end
                    else
                    begin
                        flush_next = flush_reg + 1'b1;
                    end
                    state_next = bblur_pkg::ST_DIV;
                end
                else
                begin
                    fx_next = fx_reg + 1'b1;
                    state_next = bblur_pkg::ST_FL_RD;
                end
            end

            bblur_pkg::ST_DIV:
            begin
                if ((res_num_reg == 2'd2) && !res_idx_reg)
                begin
                    res_idx_next = 1'b1;
                end
                else
                begin
                    state_next = bblur_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bblur_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == bblur_pkg::CFG_IDX_WIDTH)
            begin
                width_next = cfg_wdata[bblur_pkg::CFG_W_W-1:0];
            end
            else
            begin
                height_next = cfg_wdata;
            end
            col_next = '0;
            row_next = '0;
            flush_next = '0;
            win0_next = '0;
            win1_next = '0;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (fifo_pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (fifo_push && !fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end
        else if (!fifo_push && fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bblur_pkg::ST_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            flush_reg <= '0;
            width_reg <= bblur_pkg::WIDTH_RESET;
            height_reg <= bblur_pkg::HEIGHT_RESET;
            win0_reg <= '0;
            win1_reg <= '0;
            res_num_reg <= '0;
            res_idx_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            row_reg <= row_next;
            flush_reg <= flush_next;
            width_reg <= width_next;
            height_reg <= height_next;
            win0_reg <= win0_next;
            win1_reg <= win1_next;
            res_num_reg <= res_num_next;
            res_idx_reg <= res_idx_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
        acc_reg <= acc_next;
        acc_cnt_reg <= acc_cnt_next;
        fx_reg <= fx_next;
        fhi_reg <= fhi_next;
        if (fifo_push)
        begin
            fifo_mem[tail_reg] <= push_entry;
        end
    end

    // The middle row moves up and the new pixel takes its place in the same column.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[col_reg] <= mid_rd_reg;
            middle_mem[col_reg] <= pix_reg;
        end
        up_rd_reg <= upper_mem[rd_addr];
        mid_rd_reg <= middle_mem[rd_addr];
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata = fifo_mem[head_reg].data;
    assign m_tlast = fifo_mem[head_reg].run_last;
    assign m_tuser = fifo_mem[head_reg].frame_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblur_pkg::ST_DIV) |->
        (fifo_cnt_reg != (bblur_pkg::FIFO_AW+1)'(bblur_pkg::FIFO_DEPTH)))
        else $error("result pushed into a full output queue");

    a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bblur_pkg::ST_DIV) && res_idx_reg) |-> (res_num_reg == 2'd2))
        else $error("second result divided for a transaction with one result");

    a_pix_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblur_pkg::ST_PIX) |->
        ($past(state_reg) == bblur_pkg::ST_IDLE) && $past(s_tvalid && s_tready))
        else $error("window update without an accepted pixel");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end flagged on a result that does not close its transaction");

endmodule

`default_nettype wire
